### sv/tsvg_pkg.sv
// shared types, constants and microcode program of the tilemap strip vertex generator
package tsvg_pkg;

  localparam int MAX_MAP_WIDTH_DEF = 1024;
  localparam int MAX_ROWS_DEF      = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int ID_W       = 12;
  localparam int MW_W       = 11;
  localparam int SZ_W       = 9;
  localparam int TA_W       = 13;
  localparam int POS_W      = 19;
  localparam int TEX_W      = 29;
  localparam int IDX_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 5;
  localparam int SZ_MAX     = 256;
  localparam int TA_MAX     = 4096;
  localparam int CFG_RESET  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 2'd2;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_DIV_RCP,
    OP_WAIT_RCP,
    OP_DIV_QR,
    OP_WAIT_QR,
    OP_MUL_S,
    OP_MUL_T,
    OP_MUL_X,
    OP_MUL_Y,
    OP_EMIT,
    OP_UPDATE
  } op_e;

  typedef enum logic [1:0] {
    SK_NEVER,
    SK_FIRST,
    SK_LAST_COL
  } skip_e;

  typedef enum logic [1:0] {
    LS_NEVER,
    LS_LAST_COL,
    LS_ALWAYS
  } last_e;

  typedef struct packed {
    op_e        op;
    logic       kind;
    logic       right;
    logic       bottom;
    logic [1:0] idx_off;
    skip_e      skip;
    last_e      last;
    logic       wrap;
  } ucw_t;

  typedef struct packed {
    op_e        op;
    logic       kind;
    logic       right;
    logic       bottom;
    logic [1:0] idx_off;
    last_e      last;
    logic       fire;
    logic       emit;
  } ctl_t;

  typedef struct packed {
    logic first;
    logic last_col;
    logic div_busy;
    logic out_free;
  } stat_t;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd19;

  function automatic ucw_t mk(input op_e op, input logic kind, input logic right,
                              input logic bottom, input logic [1:0] off,
                              input skip_e sk, input last_e ls, input logic wrap);
    ucw_t w;
    w.op      = op;
    w.kind    = kind;
    w.right   = right;
    w.bottom  = bottom;
    w.idx_off = off;
    w.skip    = sk;
    w.last    = ls;
    w.wrap    = wrap;
    return w;
  endfunction

  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      5'd0:    w = mk(OP_WAIT_IN,  1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd1:    w = mk(OP_DIV_RCP,  1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd2:    w = mk(OP_WAIT_RCP, 1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd3:    w = mk(OP_DIV_QR,   1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd4:    w = mk(OP_WAIT_QR,  1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd5:    w = mk(OP_MUL_S,    1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd6:    w = mk(OP_MUL_T,    1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd7:    w = mk(OP_MUL_X,    1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd8:    w = mk(OP_MUL_Y,    1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd9:    w = mk(OP_EMIT,     1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd10:   w = mk(OP_EMIT,     1'b0, 1'b1, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd11:   w = mk(OP_EMIT,     1'b0, 1'b0, 1'b1, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd12:   w = mk(OP_EMIT,     1'b0, 1'b1, 1'b1, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd13:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b0);
      5'd14:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd0, SK_FIRST,    LS_NEVER,    1'b0);
      5'd15:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd1, SK_NEVER,    LS_NEVER,    1'b0);
      5'd16:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd2, SK_NEVER,    LS_NEVER,    1'b0);
      5'd17:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd3, SK_NEVER,    LS_LAST_COL, 1'b0);
      5'd18:   w = mk(OP_EMIT,     1'b1, 1'b0, 1'b0, 2'd3, SK_LAST_COL, LS_ALWAYS,   1'b0);
      default: w = mk(OP_UPDATE,   1'b0, 1'b0, 1'b0, 2'd0, SK_NEVER,    LS_NEVER,    1'b1);
    endcase
    return w;
  endfunction

endpackage

### sv/tsvg_div.sv
// restoring divider, one quotient bit per cycle
module tsvg_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

### sv/tsvg_seq.sv
// microcode sequencer: step counter, program table decode, wait conditions and skipped emit steps
module tsvg_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tsvg_pkg::stat_t stat_i,
  output tsvg_pkg::ctl_t  ctl_o
);
  import tsvg_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucw_t              cw;
  logic              skip;
  logic              go;

  always_comb begin
    cw = ucode(step_q);
    unique case (cw.skip)
      SK_NEVER:    skip = 1'b0;
      SK_FIRST:    skip = stat_i.first;
      SK_LAST_COL: skip = stat_i.last_col;
      default:     skip = 1'b0;
    endcase
    unique case (cw.op)
      OP_WAIT_IN:              go = in_valid_i;
      OP_WAIT_RCP, OP_WAIT_QR: go = !stat_i.div_busy;
      OP_EMIT:                 go = skip || stat_i.out_free;
      default:                 go = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = cw.wrap ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctl_o.op      = cw.op;
    ctl_o.kind    = cw.kind;
    ctl_o.right   = cw.right;
    ctl_o.bottom  = cw.bottom;
    ctl_o.idx_off = cw.idx_off;
    ctl_o.last    = cw.last;
    ctl_o.fire    = go;
    ctl_o.emit    = go && (cw.op == OP_EMIT) && !skip;
  end

  assign in_ready_o = (cw.op == OP_WAIT_IN);

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST)
    else $error("step counter left the program");
`endif

endmodule

### sv/tsvg_dp.sv
// datapath: clamps, shared multiplier, divider, tile counters and output word register
module tsvg_dp #(
  parameter int MAX_MAP_WIDTH = tsvg_pkg::MAX_MAP_WIDTH_DEF,
  parameter int MAX_ROWS      = tsvg_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = tsvg_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tsvg_pkg::ID_W-1:0]  tile_id_i,
  input  logic [tsvg_pkg::MW_W-1:0]  map_width_i,
  input  logic [tsvg_pkg::SZ_W-1:0]  tile_size_i,
  input  logic [tsvg_pkg::TA_W-1:0]  tiles_across_i,
  input  tsvg_pkg::ctl_t             ctl_i,
  output tsvg_pkg::stat_t            stat_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [tsvg_pkg::POS_W-1:0] pos_x_o,
  output logic [tsvg_pkg::POS_W-1:0] pos_y_o,
  output logic [tsvg_pkg::TEX_W-1:0] tex_s_o,
  output logic [tsvg_pkg::TEX_W-1:0] tex_t_o,
  output logic [tsvg_pkg::IDX_W-1:0] strip_index_o,
  output logic                       tile_last_o,
  output logic                       row_end_o
);
  import tsvg_pkg::*;

  localparam int RCP_W = FRACTION_BITS + 1;
  localparam int NUM_W = (RCP_W > ID_W) ? RCP_W : ID_W;
  localparam int B_W   = ID_W;
  localparam int P_W   = RCP_W + B_W;
  localparam int EXT_W = (P_W > TEX_W) ? P_W : TEX_W;
  localparam int COL_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W = 14;

  logic [CMP_W-1:0] w_c;
  logic [SZ_W-1:0]  sz_c;
  logic [TA_W-1:0]  ta_c;

  logic [ID_W-1:0]  id_q;
  logic [RCP_W-1:0] recip_q;
  logic [ID_W-1:0]  quo_q;
  logic [ID_W-1:0]  rem_q;
  logic [TEX_W-1:0] s_q, t_q;
  logic [POS_W-1:0] x_q, y_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [RCP_W-1:0] mul_a;
  logic [B_W-1:0]   mul_b;
  logic [P_W-1:0]   prod;
  logic [EXT_W-1:0] prod_ext;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic             div_busy;
  logic [NUM_W-1:0] div_quo;
  logic [TA_W-1:0]  div_rem;

  logic             first;
  logic             last_col;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [POS_W-1:0] pos_x_q, pos_x_d;
  logic [POS_W-1:0] pos_y_q, pos_y_d;
  logic [TEX_W-1:0] tex_s_q, tex_s_d;
  logic [TEX_W-1:0] tex_t_q, tex_t_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             tile_last_q, tile_last_d;
  logic             row_end_q, row_end_d;

  // register clamps
  always_comb begin
    if (map_width_i == '0) begin
      w_c = CMP_W'(1);
    end else if (CMP_W'(map_width_i) > CMP_W'(MAX_MAP_WIDTH)) begin
      w_c = CMP_W'(MAX_MAP_WIDTH);
    end else begin
      w_c = CMP_W'(map_width_i);
    end
    sz_c = (tile_size_i > SZ_W'(SZ_MAX)) ? SZ_W'(SZ_MAX) : tile_size_i;
    if (tiles_across_i == '0) begin
      ta_c = TA_W'(1);
    end else if (tiles_across_i > TA_W'(TA_MAX)) begin
      ta_c = TA_W'(TA_MAX);
    end else begin
      ta_c = tiles_across_i;
    end
  end

  assign first    = (col_q == '0);
  assign last_col = (CMP_W'(col_q) + CMP_W'(1)) >= w_c;

  // divider
  assign div_start = ctl_i.fire && ((ctl_i.op == OP_DIV_RCP) || (ctl_i.op == OP_DIV_QR));
  assign div_num   = (ctl_i.op == OP_DIV_RCP) ? (NUM_W'(1) << FRACTION_BITS) : NUM_W'(id_q);

  tsvg_div #(
    .NUM_W (NUM_W),
    .DEN_W (TA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (ta_c),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // shared multiplier
  always_comb begin
    unique case (ctl_i.op)
      OP_MUL_S: begin
        mul_a = recip_q;
        mul_b = rem_q;
      end
      OP_MUL_T: begin
        mul_a = recip_q;
        mul_b = quo_q;
      end
      OP_MUL_X: begin
        mul_a = RCP_W'(sz_c);
        mul_b = B_W'(col_q);
      end
      OP_MUL_Y: begin
        mul_a = RCP_W'(sz_c);
        mul_b = B_W'(row_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = P_W'(mul_a) * P_W'(mul_b);
    prod_ext = EXT_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire) begin
      unique case (ctl_i.op)
        OP_WAIT_IN:  id_q <= tile_id_i;
        OP_WAIT_RCP: recip_q <= div_quo[RCP_W-1:0];
        OP_WAIT_QR: begin
          quo_q <= div_quo[ID_W-1:0];
          rem_q <= div_rem[ID_W-1:0];
        end
        OP_MUL_S:    s_q <= prod_ext[TEX_W-1:0];
        OP_MUL_T:    t_q <= prod_ext[TEX_W-1:0];
        OP_MUL_X:    x_q <= prod_ext[POS_W-1:0];
        OP_MUL_Y:    y_q <= prod_ext[POS_W-1:0];
        default:     ;
      endcase
    end
  end

  // column and row tracking
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctl_i.fire && (ctl_i.op == OP_UPDATE)) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(MAX_ROWS - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // output word
  always_comb begin
    kind_d  = ctl_i.kind;
    pos_x_d = '0;
    pos_y_d = '0;
    tex_s_d = '0;
    tex_t_d = '0;
    idx_d   = '0;
    if (ctl_i.kind) begin
      idx_d = IDX_W'({col_q, 2'b00}) + IDX_W'(ctl_i.idx_off);
    end else begin
      pos_x_d = x_q + (ctl_i.right ? POS_W'(sz_c) : '0);
      pos_y_d = y_q + (ctl_i.bottom ? POS_W'(sz_c) : '0);
      tex_s_d = s_q + (ctl_i.right ? TEX_W'(recip_q) : '0);
      tex_t_d = t_q + (ctl_i.bottom ? TEX_W'(recip_q) : '0);
    end
    unique case (ctl_i.last)
      LS_ALWAYS:   tile_last_d = 1'b1;
      LS_LAST_COL: tile_last_d = last_col;
      default:     tile_last_d = 1'b0;
    endcase
    row_end_d = last_col;
    if (ctl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      kind_q      <= kind_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      tex_s_q     <= tex_s_d;
      tex_t_q     <= tex_t_d;
      idx_q       <= idx_d;
      tile_last_q <= tile_last_d;
      row_end_q   <= row_end_d;
    end
  end

  always_comb begin
    stat_o.first    = first;
    stat_o.last_col = last_col;
    stat_o.div_busy = div_busy;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign tex_s_o       = tex_s_q;
  assign tex_t_o       = tex_t_q;
  assign strip_index_o = idx_q;
  assign tile_last_o   = tile_last_q;
  assign row_end_o     = row_end_q;

`ifndef NO_ASSERTIONS
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < MAX_ROWS)
    else $error("row counter past wrap point");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.fire && (ctl_i.op == OP_WAIT_QR)) |=> (TA_W'(rem_q) < ta_c))
    else $error("sheet column not below tiles across");
  a_last_on_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tile_last_q) |-> kind_q)
    else $error("tile end flagged on a vertex word");
`endif

endmodule

### sv/tilemap_strip_vertex_generator.sv
// top level of the tilemap strip vertex generator: config registers, sequencer and datapath
//
// channel  dir  handshake                  payload
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in   in_valid_i / in_ready_o    tile_id_i
// out      out  out_valid_o / out_ready_i  kind_o, pos_x_o, pos_y_o, tex_s_o, tex_t_o,
//                                          strip_index_o, tile_last_o, row_end_o
//
// the divider works on NUM_W = max(FRACTION_BITS + 1, 12) bits
// each tile makes two passes through the shared one-bit-per-cycle divider: reciprocal, then quotient and remainder
// ten output steps follow; a skipped index step passes without emitting a word or waiting on the output
// a stalled output word holds the sequencer on its emit step
// reset sets all config registers to 16, column and row to zero
module tilemap_strip_vertex_generator #(
  parameter int MAX_MAP_WIDTH = tsvg_pkg::MAX_MAP_WIDTH_DEF,
  parameter int MAX_ROWS      = tsvg_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = tsvg_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsvg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tsvg_pkg::ID_W-1:0]       tile_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic [tsvg_pkg::POS_W-1:0]      pos_x_o,
  output logic [tsvg_pkg::POS_W-1:0]      pos_y_o,
  output logic [tsvg_pkg::TEX_W-1:0]      tex_s_o,
  output logic [tsvg_pkg::TEX_W-1:0]      tex_t_o,
  output logic [tsvg_pkg::IDX_W-1:0]      strip_index_o,
  output logic                            tile_last_o,
  output logic                            row_end_o
);
  import tsvg_pkg::*;

  logic [MW_W-1:0] map_width_q, map_width_d;
  logic [SZ_W-1:0] tile_size_q, tile_size_d;
  logic [TA_W-1:0] tiles_across_q, tiles_across_d;
  logic            cfg_we;
  ctl_t            ctl;
  stat_t           stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    map_width_d    = map_width_q;
    tile_size_d    = tile_size_q;
    tiles_across_d = tiles_across_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_MAP_WIDTH:    map_width_d    = cfg_data_i[MW_W-1:0];
        REG_TILE_SIZE:    tile_size_d    = cfg_data_i[SZ_W-1:0];
        REG_TILES_ACROSS: tiles_across_d = cfg_data_i[TA_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q    <= MW_W'(CFG_RESET);
      tile_size_q    <= SZ_W'(CFG_RESET);
      tiles_across_q <= TA_W'(CFG_RESET);
    end else begin
      map_width_q    <= map_width_d;
      tile_size_q    <= tile_size_d;
      tiles_across_q <= tiles_across_d;
    end
  end

  tsvg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  tsvg_dp #(
    .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tile_id_i      (tile_id_i),
    .map_width_i    (map_width_q),
    .tile_size_i    (tile_size_q),
    .tiles_across_i (tiles_across_q),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .tex_s_o        (tex_s_o),
    .tex_t_o        (tex_t_o),
    .strip_index_o  (strip_index_o),
    .tile_last_o    (tile_last_o),
    .row_end_o      (row_end_o)
  );

endmodule

### tb/tb_tilemap_strip_vertex_generator.sv
`timescale 1ns / 100ps
// testbench of the tilemap strip vertex generator: scoreboard with predictor, directed and random tiles
module tb_tilemap_strip_vertex_generator;
  import tsvg_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 20;
  localparam int LONG_ITEMS    = 6;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic [IDX_W-1:0] strip_index;
    logic             tile_last;
    logic             row_end;
  } vert_word_t;

  class strip_scoreboard;
    logic [MW_W-1:0] map_width;
    logic [SZ_W-1:0] tile_size;
    logic [TA_W-1:0] tiles_across;
    logic [9:0]      column;
    logic [9:0]      row;
    vert_word_t      pending_words[$];
    int              mismatches;
    int              words;
    int              tiles;
    int              reg_writes;
    int              row_wraps;
    int              short_rows;

    function new();
      map_width    = MW_W'(CFG_RESET);
      tile_size    = SZ_W'(CFG_RESET);
      tiles_across = TA_W'(CFG_RESET);
      column       = '0;
      row          = '0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAP_WIDTH:    map_width    = data[MW_W-1:0];
        REG_TILE_SIZE:    tile_size    = data[SZ_W-1:0];
        REG_TILES_ACROSS: tiles_across = data[TA_W-1:0];
        default: ;
      endcase
      reg_writes++;
    endfunction

    function void add_word(input bit kind, input int unsigned px, input int unsigned py,
                           input int unsigned ts, input int unsigned tt,
                           input int unsigned ix, input bit last, input bit rend);
      vert_word_t w;
      w.kind        = kind;
      w.pos_x       = px[POS_W-1:0];
      w.pos_y       = py[POS_W-1:0];
      w.tex_s       = ts[TEX_W-1:0];
      w.tex_t       = tt[TEX_W-1:0];
      w.strip_index = ix[IDX_W-1:0];
      w.tile_last   = last;
      w.row_end     = rend;
      pending_words.push_back(w);
    endfunction

    function void note_tile(input logic [ID_W-1:0] id);
      int unsigned w;
      int unsigned sz;
      int unsigned ta;
      int unsigned recip;
      int unsigned s;
      int unsigned t;
      int unsigned x;
      int unsigned y;
      int unsigned base;
      int unsigned ix[$];
      bit          first;
      bit          last_col;
      w = map_width;
      if (w == 0) w = 1;
      else if (w > MAX_MAP_WIDTH_DEF) w = MAX_MAP_WIDTH_DEF;
      sz = tile_size;
      if (sz > SZ_MAX) sz = SZ_MAX;
      ta = tiles_across;
      if (ta == 0) ta = 1;
      else if (ta > TA_MAX) ta = TA_MAX;
      recip    = (32'd1 << FRACTION_BITS_DEF) / ta;
      s        = (id % ta) * recip;
      t        = (id / ta) * recip;
      x        = column * sz;
      y        = row * sz;
      first    = (column == 0);
      last_col = (column + 1 >= w);
      base     = column * 4;
      if (column >= w) short_rows++;
      add_word(1'b0, x, y, s, t, 0, 1'b0, last_col);
      add_word(1'b0, x + sz, y, s + recip, t, 0, 1'b0, last_col);
      add_word(1'b0, x, y + sz, s, t + recip, 0, 1'b0, last_col);
      add_word(1'b0, x + sz, y + sz, s + recip, t + recip, 0, 1'b0, last_col);
      ix.push_back(base);
      if (!first) ix.push_back(base);
      ix.push_back(base + 1);
      ix.push_back(base + 2);
      ix.push_back(base + 3);
      if (!last_col) ix.push_back(base + 3);
      foreach (ix[i]) add_word(1'b1, 0, 0, 0, 0, ix[i], i == ix.size() - 1, last_col);
      if (last_col) begin
        column = '0;
        if (row == MAX_ROWS_DEF - 1) row_wraps++;
        row = 10'((row + 1) % MAX_ROWS_DEF);
      end else begin
        column = column + 10'd1;
      end
      tiles++;
    endfunction

    function void check_word(input vert_word_t got);
      vert_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: kind %0d x %0d y %0d idx %0d", got.kind, got.pos_x,
                   got.pos_y, got.strip_index);
        return;
      end
      want = pending_words.pop_front();
      words++;
      if (got.kind !== want.kind || got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.tex_s !== want.tex_s || got.tex_t !== want.tex_t ||
          got.strip_index !== want.strip_index || got.tile_last !== want.tile_last ||
          got.row_end !== want.row_end) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("word %0d exp kind %0d x %0d y %0d s %0d t %0d idx %0d last %0d end %0d",
                   words, want.kind, want.pos_x, want.pos_y, want.tex_s, want.tex_t,
                   want.strip_index, want.tile_last, want.row_end);
          $display("word %0d act kind %0d x %0d y %0d s %0d t %0d idx %0d last %0d end %0d",
                   words, got.kind, got.pos_x, got.pos_y, got.tex_s, got.tex_t,
                   got.strip_index, got.tile_last, got.row_end);
        end
      end
    endfunction

    function int words_due();
      return pending_words.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ID_W-1:0]       tile_id_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  kind_o;
  logic [POS_W-1:0]      pos_x_o;
  logic [POS_W-1:0]      pos_y_o;
  logic [TEX_W-1:0]      tex_s_o;
  logic [TEX_W-1:0]      tex_t_o;
  logic [IDX_W-1:0]      strip_index_o;
  logic                  tile_last_o;
  logic                  row_end_o;

  logic                  idle_en;
  logic                  hold_go;
  logic                  hold_done;
  int                    cycle_count = 0;
  vert_word_t            seen_word;
  strip_scoreboard       sb;

  tilemap_strip_vertex_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tile_id_i    (tile_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .tex_s_o      (tex_s_o),
    .tex_t_o      (tex_t_o),
    .strip_index_o(strip_index_o),
    .tile_last_o  (tile_last_o),
    .row_end_o    (row_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      seen_word.kind        = kind_o;
      seen_word.pos_x       = pos_x_o;
      seen_word.pos_y       = pos_y_o;
      seen_word.tex_s       = tex_s_o;
      seen_word.tex_t       = tex_t_o;
      seen_word.strip_index = strip_index_o;
      seen_word.tile_last   = tile_last_o;
      seen_word.row_end     = row_end_o;
      sb.check_word(seen_word);
    end
  end

  // receiver: one long hold when asked, random stall bursts while idling is on
  initial begin : sink
    out_ready_i <= 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [ID_W-1:0] rand_tile_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endcase
  endfunction

  task automatic send_tile(input logic [ID_W-1:0] id, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tile_id_i  <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tile(id);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.words_due() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] mw, input logic [CFG_DATA_W-1:0] sz,
                              input logic [CFG_DATA_W-1:0] ta, input bit poke_unused);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_TILE_SIZE, sz);
    write_reg(REG_TILES_ACROSS, ta);
    if (poke_unused)
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int p);
    logic [CFG_DATA_W-1:0] mw;
    logic [CFG_DATA_W-1:0] sz;
    logic [CFG_DATA_W-1:0] ta;
    bit                    bursty;
    int                    gap;
    bursty = (p != RANDOM_PHASES - 1);
    drain();
    idle_en <= bursty;
    case ($urandom_range(0, 4))
      0:       mw = '0;
      1:       mw = CFG_DATA_W'(MAX_MAP_WIDTH_DEF);
      2:       mw = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
      default: mw = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 4))
      0:       sz = '0;
      1:       sz = CFG_DATA_W'(SZ_MAX);
      2:       sz = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
      default: sz = CFG_DATA_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 4))
      0:       ta = '0;
      1:       ta = CFG_DATA_W'(TA_MAX);
      2:       ta = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
      default: ta = CFG_DATA_W'($urandom_range(1, 40));
    endcase
    write_config(mw, sz, ta, 1'($urandom_range(0, 1)));
    if (p == 0) hold_go <= 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (p == 1 && i == PHASE_ITEMS / 2) drain();
      gap = (bursty && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 10)) : 0;
      send_tile(rand_tile_id(), gap);
    end
  endtask

  // a few tiles on the widest map at the largest sizes, then a few one-tile rows
  task automatic run_long_rows();
    drain();
    idle_en <= 1'b0;
    write_config(CFG_DATA_W'(MAX_MAP_WIDTH_DEF), CFG_DATA_W'(SZ_MAX), CFG_DATA_W'(TA_MAX),
                 1'b0);
    repeat (LONG_ITEMS) send_tile(rand_tile_id(), 0);
    drain();
    write_config(CFG_DATA_W'(1), CFG_DATA_W'(SZ_MAX), CFG_DATA_W'(TA_MAX), 1'b0);
    repeat (LONG_ITEMS) send_tile(rand_tile_id(), 0);
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    tile_id_i   <= '0;
    idle_en     <= 1'b0;
    hold_go     <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, id extremes and sheet row boundaries
    send_tile(12'd0, 0);
    send_tile(12'd4095, 0);
    send_tile(12'd15, 0);
    send_tile(12'd16, 0);
    send_tile(12'd17, 0);
    send_tile(12'd2048, 0);
    // narrower map while mid-row ends the row early
    drain();
    write_config(CFG_DATA_W'(3), CFG_DATA_W'(16), CFG_DATA_W'(16), 1'b0);
    send_tile(12'd4094, 0);
    // zero settings
    drain();
    write_config('0, '0, '0, 1'b1);
    send_tile(12'd4095, 0);
    send_tile(12'd0, 0);
    // all-ones data, saturating every register
    drain();
    write_config('1, '1, '1, 1'b0);
    send_tile(12'd4095, 0);
    send_tile(12'd0, 0);
    send_tile(12'd2731, 0);
    // two-tile rows, unit tiles, odd sheet width
    drain();
    write_config(CFG_DATA_W'(2), CFG_DATA_W'(1), CFG_DATA_W'(4095), 1'b0);
    send_tile(12'd1, 0);
    send_tile(12'd2, 0);
    send_tile(12'd4094, 0);
    send_tile(12'd3, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 2) run_long_rows();
      run_random_phase(p);
    end
    drain();

    $display("covered %0d tiles, %0d words checked, %0d register writes", sb.tiles, sb.words,
             sb.reg_writes);
    $display("row counter wrapped %0d times, %0d rows ended early by a narrower map",
             sb.row_wraps, sb.short_rows);
    if (sb.mismatches == 0 && sb.words_due() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d words still due", sb.mismatches, sb.words_due());
      $display("FAIL");
    end
    $finish;
  end

endmodule

### tilemap_strip_vertex_generator.f
sv/tsvg_pkg.sv
sv/tsvg_div.sv
sv/tsvg_seq.sv
sv/tsvg_dp.sv
sv/tilemap_strip_vertex_generator.sv
tb/tb_tilemap_strip_vertex_generator.sv
